// ----- hdl/gpr_pkg.sv -----
// Shared types, constants and register map of the GPIO port register block.
package gpr_pkg;

    // Number of pins in the port (1 to 16).
    localparam int PIN_COUNT = 16;

    localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
    localparam logic [31:0] MUX_MASK = 32'((64'd1 << (2 * PIN_COUNT)) - 64'd1);

    // Word offsets (byte offset / 4) of the register window.
    localparam logic [3:0] WORD_FER       = 4'd0;
    localparam logic [3:0] WORD_FER_SET   = 4'd1;
    localparam logic [3:0] WORD_FER_CLR   = 4'd2;
    localparam logic [3:0] WORD_DATA      = 4'd3;
    localparam logic [3:0] WORD_DATA_SET  = 4'd4;
    localparam logic [3:0] WORD_DATA_CLR  = 4'd5;
    localparam logic [3:0] WORD_DIR       = 4'd6;
    localparam logic [3:0] WORD_DIR_SET   = 4'd7;
    localparam logic [3:0] WORD_DIR_CLR   = 4'd8;
    localparam logic [3:0] WORD_INEN      = 4'd9;
    localparam logic [3:0] WORD_INEN_SET  = 4'd10;
    localparam logic [3:0] WORD_INEN_CLR  = 4'd11;
    localparam logic [3:0] WORD_MUX       = 4'd12;

    typedef enum logic [2:0] {
        GRP_FER,
        GRP_DATA,
        GRP_DIR,
        GRP_INEN,
        GRP_MUX
    } reg_group_t;

    typedef enum logic [1:0] {
        WR_PLAIN,
        WR_SET,
        WR_CLEAR
    } wr_kind_t;

    // One bus request.
    typedef struct packed {
        logic        write;
        logic [5:0]  address;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } req_t;

    // Decoded address.
    typedef struct packed {
        logic       err;
        reg_group_t group;
        wr_kind_t   kind;
    } dec_t;

    // One result.
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic [15:0] pin_drive;
        logic [15:0] pin_output_enable;
        logic [15:0] function_enable;
        logic [31:0] mux_select;
    } rsp_t;

endpackage

// ----- hdl/gpr_decode.sv -----
// Address decoder: splits a byte offset into register group and write kind.
module gpr_decode (
    input  logic [5:0]    address,
    output gpr_pkg::dec_t dec
);

    logic [3:0] word;

    assign word = address[5:2];

    // Misaligned or past the mux register is an error; otherwise map the word.
    always_comb
    begin
        dec.err = (address[1:0] != 2'd0) || (word > gpr_pkg::WORD_MUX);

        case (word)
            gpr_pkg::WORD_FER, gpr_pkg::WORD_FER_SET, gpr_pkg::WORD_FER_CLR:
                dec.group = gpr_pkg::GRP_FER;
            gpr_pkg::WORD_DATA, gpr_pkg::WORD_DATA_SET, gpr_pkg::WORD_DATA_CLR:
                dec.group = gpr_pkg::GRP_DATA;
            gpr_pkg::WORD_DIR, gpr_pkg::WORD_DIR_SET, gpr_pkg::WORD_DIR_CLR:
                dec.group = gpr_pkg::GRP_DIR;
            gpr_pkg::WORD_INEN, gpr_pkg::WORD_INEN_SET, gpr_pkg::WORD_INEN_CLR:
                dec.group = gpr_pkg::GRP_INEN;
            gpr_pkg::WORD_MUX:
                dec.group = gpr_pkg::GRP_MUX;
            default:
                dec.group = gpr_pkg::GRP_FER;
        endcase

        case (word)
            gpr_pkg::WORD_FER_SET, gpr_pkg::WORD_DATA_SET,
            gpr_pkg::WORD_DIR_SET, gpr_pkg::WORD_INEN_SET:
                dec.kind = gpr_pkg::WR_SET;
            gpr_pkg::WORD_FER_CLR, gpr_pkg::WORD_DATA_CLR,
            gpr_pkg::WORD_DIR_CLR, gpr_pkg::WORD_INEN_CLR:
                dec.kind = gpr_pkg::WR_CLEAR;
            default:
                dec.kind = gpr_pkg::WR_PLAIN;
        endcase
    end

endmodule

// ----- hdl/gpr_regs.sv -----
// Port state registers, their update and the result of one request.
module gpr_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           update,
    input  gpr_pkg::req_t  req,
    input  gpr_pkg::dec_t  dec,
    output gpr_pkg::rsp_t  rsp
);

    logic [15:0] fer_reg,  fer_next;
    logic [15:0] data_reg, data_next;
    logic [15:0] dir_reg,  dir_next;
    logic [15:0] inen_reg, inen_next;
    logic [31:0] mux_reg,  mux_next;

    logic [15:0] cur;
    logic [15:0] mask;
    logic [15:0] wr_val;
    logic [15:0] levels;
    logic [15:0] data_rd;
    logic [31:0] rd;
    logic        do_write;

    assign mask     = req.write_data[15:0] & gpr_pkg::PIN_MASK;
    assign levels   = req.pin_levels & gpr_pkg::PIN_MASK;
    assign do_write = req.write && !dec.err;

    // Select the addressed 16-bit register.
    always_comb
    begin
        case (dec.group)
            gpr_pkg::GRP_FER:  cur = fer_reg;
            gpr_pkg::GRP_DATA: cur = data_reg;
            gpr_pkg::GRP_DIR:  cur = dir_reg;
            gpr_pkg::GRP_INEN: cur = inen_reg;
            default:           cur = 16'd0;
        endcase
    end

    // Plain, set or clear write value.
    always_comb
    begin
        case (dec.kind)
            gpr_pkg::WR_PLAIN: wr_val = mask;
            gpr_pkg::WR_SET:   wr_val = (cur | mask) & gpr_pkg::PIN_MASK;
            gpr_pkg::WR_CLEAR: wr_val = cur & ~mask & gpr_pkg::PIN_MASK;
            default:           wr_val = mask;
        endcase
    end

    // Next state of every register.
    always_comb
    begin
        fer_next  = fer_reg;
        data_next = data_reg;
        dir_next  = dir_reg;
        inen_next = inen_reg;
        mux_next  = mux_reg;
        if (do_write)
        begin
            case (dec.group)
                gpr_pkg::GRP_FER:  fer_next  = wr_val;
                gpr_pkg::GRP_DATA: data_next = wr_val;
                gpr_pkg::GRP_DIR:  dir_next  = wr_val;
                gpr_pkg::GRP_INEN: inen_next = wr_val;
                gpr_pkg::GRP_MUX:  mux_next  = req.write_data & gpr_pkg::MUX_MASK;
                default:           mux_next  = mux_reg;
            endcase
        end
    end

    // Output pins report the latch, input-enabled pins the sampled level.
    assign data_rd = (data_reg & dir_reg) | (levels & inen_reg & ~dir_reg);

    // Read data; writes and errors return zero.
    always_comb
    begin
        rd = 32'd0;
        if (!req.write && !dec.err)
        begin
            case (dec.group)
                gpr_pkg::GRP_FER:  rd = {16'd0, fer_reg};
                gpr_pkg::GRP_DATA: rd = {16'd0, data_rd};
                gpr_pkg::GRP_DIR:  rd = {16'd0, dir_reg};
                gpr_pkg::GRP_INEN: rd = {16'd0, inen_reg};
                gpr_pkg::GRP_MUX:  rd = mux_reg;
                default:           rd = 32'd0;
            endcase
        end
    end

    // Result reflects the state after the request.
    assign rsp.read_data         = rd;
    assign rsp.access_error      = dec.err;
    assign rsp.pin_drive         = data_next;
    assign rsp.pin_output_enable = dir_next & ~fer_next;
    assign rsp.function_enable   = fer_next;
    assign rsp.mux_select        = mux_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fer_reg  <= 16'd0;
            data_reg <= 16'd0;
            dir_reg  <= 16'd0;
            inen_reg <= 16'd0;
            mux_reg  <= 32'd0;
        end
        else if (update)
        begin
            fer_reg  <= fer_next;
            data_reg <= data_next;
            dir_reg  <= dir_next;
            inen_reg <= inen_next;
            mux_reg  <= mux_next;
        end
    end

endmodule

// ----- hdl/gpio_port_register_block.sv -----
// Top level of the GPIO port register block: request register, update logic, result register.
//
// One GPIO port of 16 pins behind a 64-byte register window. Each request on the
// slave stream (s_tuser = 1 for a write, 0 for a read; s_tdata = offset, write data,
// sampled pin levels) yields exactly one result on the master stream: read data,
// an error flag in m_tuser for a misaligned or unmapped offset, and the pin-side
// outputs as they stand after the request.
// The request register loads at the edge that accepts a request, and the
// decode/update logic loads the result register once that register is free,
// which raises m_tvalid; the result is then held there until it is taken.
// Throughput is one request per cycle while m_tready does not stall the result
// stage; the register state is updated as a request moves into the result
// register, so consecutive requests see each other's writes in order.
// Reset clears all port registers (every pin a plain input, no alternate function)
// and empties both pipeline stages.
// When the receiver holds m_tready low the result stays in place, the request
// stage fills, and then s_tready drops until the result is taken.
module gpio_port_register_block (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // address[5:0], write_data[37:6], pin_levels[53:38], zero pad
    input  logic         s_tuser,   // operation: 1 write, 0 read
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // read_data[31:0], pin_drive[47:32],
                                    // pin_output_enable[63:48], function_enable[79:64],
                                    // mux_select[111:80]
    output logic         m_tuser    // access_error
);

    logic          in_valid_reg;
    gpr_pkg::req_t req_reg;
    logic          out_valid_reg;
    gpr_pkg::rsp_t rsp_reg;

    gpr_pkg::dec_t dec;
    gpr_pkg::rsp_t rsp;
    logic          out_free;
    logic          advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    gpr_decode u_decode (
        .address (req_reg.address),
        .dec     (dec)
    );

    gpr_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .req    (req_reg),
        .dec    (dec),
        .rsp    (rsp)
    );

    // Request stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.write      <= s_tuser;
            req_reg.address    <= s_tdata[5:0];
            req_reg.write_data <= s_tdata[37:6];
            req_reg.pin_levels <= s_tdata[53:38];
        end
    end

    // Result stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rsp_reg.access_error;
    assign m_tdata  = {rsp_reg.mux_select, rsp_reg.function_enable,
                       rsp_reg.pin_output_enable, rsp_reg.pin_drive, rsp_reg.read_data};

endmodule

// ----- dv/tb_gpio_port_register_block.sv -----
// Self-checking testbench for the GPIO port register block: directed table, random traffic.
module tb_gpio_port_register_block;

    timeunit 1ns;
    timeprecision 1ps;

    import gpr_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_REQUESTS  = 1730;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int HOLD_AFTER       = 300;
    localparam int DRAIN_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int PRINT_LIMIT      = 100;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Byte offsets of the register window.
    localparam logic [5:0] OFS_FER       = {WORD_FER, 2'b00};
    localparam logic [5:0] OFS_FER_SET   = {WORD_FER_SET, 2'b00};
    localparam logic [5:0] OFS_FER_CLR   = {WORD_FER_CLR, 2'b00};
    localparam logic [5:0] OFS_DATA      = {WORD_DATA, 2'b00};
    localparam logic [5:0] OFS_DATA_SET  = {WORD_DATA_SET, 2'b00};
    localparam logic [5:0] OFS_DATA_CLR  = {WORD_DATA_CLR, 2'b00};
    localparam logic [5:0] OFS_DIR       = {WORD_DIR, 2'b00};
    localparam logic [5:0] OFS_DIR_SET   = {WORD_DIR_SET, 2'b00};
    localparam logic [5:0] OFS_DIR_CLR   = {WORD_DIR_CLR, 2'b00};
    localparam logic [5:0] OFS_INEN      = {WORD_INEN, 2'b00};
    localparam logic [5:0] OFS_INEN_SET  = {WORD_INEN_SET, 2'b00};
    localparam logic [5:0] OFS_INEN_CLR  = {WORD_INEN_CLR, 2'b00};
    localparam logic [5:0] OFS_MUX       = {WORD_MUX, 2'b00};

    // Offsets that must be rejected.
    localparam logic [5:0] OFS_MISALIGNED_LOW  = 6'h01;
    localparam logic [5:0] OFS_MISALIGNED_DATA = 6'h0d;
    localparam logic [5:0] OFS_UNMAPPED        = 6'h34;
    localparam logic [5:0] OFS_TOP             = 6'h3f;

    // One row of the directed table; typed marks rows whose read data and error are given here.
    typedef struct packed {
        logic        op;
        logic [5:0]  address;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
        logic        typed;
        logic [31:0] read_data;
        logic        access_error;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Reset values and bad offsets.
        '{OP_READ,  OFS_FER,             32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,  OFS_DATA,            32'h0000_0000, 16'hffff, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,  OFS_MUX,             32'h0000_0000, 16'hffff, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_WRITE, OFS_MISALIGNED_DATA, 32'hffff_ffff, 16'h0000, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_READ,  OFS_MISALIGNED_LOW,  32'h0000_0000, 16'hffff, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_READ,  OFS_UNMAPPED,        32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b1},
        '{OP_WRITE, OFS_TOP,             32'hffff_ffff, 16'hffff, 1'b1, 32'h0000_0000, 1'b1},
        // Function enable through all three aliases; upper write bits are dropped.
        '{OP_WRITE, OFS_FER,             32'hffff_ffff, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,  OFS_FER,             32'h0000_0000, 16'h0000, 1'b1, 32'h0000_ffff, 1'b0},
        '{OP_WRITE, OFS_FER_CLR,         32'h0000_00ff, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_READ,  OFS_FER_SET,         32'h0000_0000, 16'h0000, 1'b1, 32'h0000_ff00, 1'b0},
        '{OP_WRITE, OFS_FER_SET,         32'h0000_000f, 16'h0000, 1'b0, 32'h0,         1'b0},
        // Data latch, direction and input enable.
        '{OP_WRITE, OFS_DATA,            32'ha5a5_5a5a, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_DATA_SET,        32'h0000_0001, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_DATA_CLR,        32'h0000_0002, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_DIR,             32'h00ff_00ff, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_DIR_SET,         32'hffff_0f00, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_DIR_CLR,         32'h0000_0001, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_INEN,            32'hffff_ffff, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{OP_WRITE, OFS_INEN_CLR,        32'h0000_f000, 16'h0000, 1'b0, 32'h0,         1'b0},
        // Data reads mixing output pins, input-enabled pins and dead pins.
        '{OP_READ,  OFS_DATA,            32'h0000_0000, 16'hffff, 1'b0, 32'h0,         1'b0},
        '{OP_READ,  OFS_DATA_CLR,        32'h0000_0000, 16'h0000, 1'b0, 32'h0,         1'b0},
        // Mux register at its extreme.
        '{OP_WRITE, OFS_MUX,             32'hffff_ffff, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,  OFS_MUX,             32'h0000_0000, 16'h0000, 1'b1, 32'hffff_ffff, 1'b0}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;     // address[5:0], write_data[37:6], pin_levels[53:38], zero pad
    logic         s_tuser = 1'b0;   // operation: 1 write, 0 read
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // read_data[31:0], pin_drive[47:32],
                                    // pin_output_enable[63:48], function_enable[79:64],
                                    // mux_select[111:80]
    logic         m_tuser;          // access_error

    // Predicted port state, indexed by register group.
    logic [15:0]  port_regs [4];
    logic [31:0]  port_mux;

    rsp_t         pending_results [$];
    int           error_count = 0;
    int           requests_sent = 0;
    int           cycle_count = 0;
    bit           steady_phase = 1'b0;
    bit           long_hold_done = 1'b0;

    gpio_port_register_block dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
        end
    endtask

    // Applies one bus request to the predicted port state and returns the result it yields.
    function automatic rsp_t predict_access(input req_t r);
        rsp_t       res;
        logic [3:0] word;
        logic [15:0] mask;
        logic [15:0] dir;
        reg_group_t grp;
        wr_kind_t   kind;
        res = '0;
        word = r.address[5:2];
        mask = r.write_data[15:0] & PIN_MASK;

        case (word)
            WORD_FER, WORD_FER_SET, WORD_FER_CLR:     grp = GRP_FER;
            WORD_DATA, WORD_DATA_SET, WORD_DATA_CLR:  grp = GRP_DATA;
            WORD_DIR, WORD_DIR_SET, WORD_DIR_CLR:     grp = GRP_DIR;
            WORD_INEN, WORD_INEN_SET, WORD_INEN_CLR:  grp = GRP_INEN;
            default:                                  grp = GRP_MUX;
        endcase
        case (word)
            WORD_FER_SET, WORD_DATA_SET, WORD_DIR_SET, WORD_INEN_SET:  kind = WR_SET;
            WORD_FER_CLR, WORD_DATA_CLR, WORD_DIR_CLR, WORD_INEN_CLR:  kind = WR_CLEAR;
            default:                                                  kind = WR_PLAIN;
        endcase

        if (r.address[1:0] != 2'b00 || r.address > OFS_MUX)
        begin
            res.access_error = 1'b1;
        end
        else if (grp == GRP_MUX)
        begin
            if (r.write)
                port_mux = r.write_data & MUX_MASK;
            else
                res.read_data = port_mux;
        end
        else if (r.write)
        begin
            case (kind)
                WR_SET:   port_regs[int'(grp)] = (port_regs[int'(grp)] | mask) & PIN_MASK;
                WR_CLEAR: port_regs[int'(grp)] = port_regs[int'(grp)] & ~mask & PIN_MASK;
                default:  port_regs[int'(grp)] = mask;
            endcase
        end
        else if (grp == GRP_DATA)
        begin
            // Output pins read their latch; other pins read the pad only when input-enabled.
            dir = port_regs[int'(GRP_DIR)];
            res.read_data = {16'h0000, ((port_regs[int'(GRP_DATA)] & dir) |
                             (r.pin_levels & port_regs[int'(GRP_INEN)] & ~dir)) & PIN_MASK};
        end
        else
        begin
            res.read_data = {16'h0000, port_regs[int'(grp)]};
        end

        res.pin_drive = port_regs[int'(GRP_DATA)];
        res.pin_output_enable = port_regs[int'(GRP_DIR)] & ~port_regs[int'(GRP_FER)];
        res.function_enable = port_regs[int'(GRP_FER)];
        res.mux_select = port_mux;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long, none in steady stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly mapped, aligned offsets; a share of arbitrary ones for the error path.
    function automatic req_t random_request();
        req_t r;
        int   roll;
        r.write = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
        if ($urandom_range(0, 99) < 88)
            r.address = {4'($urandom_range(0, int'(WORD_MUX))), 2'b00};
        else
            r.address = 6'($urandom_range(0, 63));
        roll = $urandom_range(0, 9);
        case (roll)
            5, 6:    r.write_data = 32'd1 << $urandom_range(0, 31);
            7:       r.write_data = 32'hffff_ffff;
            8:       r.write_data = 32'h0000_0000;
            default: r.write_data = $urandom;
        endcase
        r.pin_levels = 16'($urandom);
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records the result it should give.
    task automatic send_request(input req_t r, input logic typed,
                                input logic [31:0] typed_read, input logic typed_err);
        rsp_t want;
        int   gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.pin_levels, r.write_data, r.address};
        s_tuser <= r.write;
        do
            @(posedge clk);
        while (!s_tready);
        want = predict_access(r);
        if (typed)
        begin
            want.read_data = typed_read;
            want.access_error = typed_err;
        end
        pending_results.push_back(want);
        requests_sent++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error("result with no request outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", m_tdata[31:0], want.read_data);
                check_field("access_error", {31'd0, m_tuser}, {31'd0, want.access_error});
                check_field("pin_drive", {16'd0, m_tdata[47:32]}, {16'd0, want.pin_drive});
                check_field("pin_output_enable", {16'd0, m_tdata[63:48]},
                            {16'd0, want.pin_output_enable});
                check_field("function_enable", {16'd0, m_tdata[79:64]},
                            {16'd0, want.function_enable});
                check_field("mux_select", m_tdata[111:80], want.mux_select);
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off that backs up the request side.
    initial
    begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!long_hold_done && requests_sent >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Timeout.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random traffic, drain.
    initial
    begin
        stim_row_t row;
        req_t      r;
        for (int g = 0; g < 4; g++)
        begin
            port_regs[g] = '0;
        end
        port_mux = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            r.write = row.op;
            r.address = row.address;
            r.write_data = row.write_data;
            r.pin_levels = row.pin_levels;
            send_request(r, row.typed, row.read_data, row.access_error);
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Every third stretch of 200 requests runs without idles on either side.
            steady_phase = ((i / 200) % 3 == 2);
            send_request(random_request(), 1'b0, 32'h0, 1'b0);
        end
        steady_phase = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
